// ----- hdl/daqbd_pkg.sv -----
package daqbd_pkg;

   // default width of the sample counter and the stored sample count
   localparam int SAMPLE_COUNT_BITS_DEFAULT = 10;

   // register reset value
   localparam int SPC_RESET = 30;
   localparam int SPC_WIDTH = 10;

   // framing words
   localparam logic [15:0] SYNC_WORD   = 16'hCACA;
   localparam logic [15:0] HEADER_WORD = 16'hEEEE;

   // event wrap detection thresholds
   localparam logic [15:0] WRAP_HIGH = 16'hF000;
   localparam logic [15:0] WRAP_LOW  = 16'h1000;

   // header word positions after 0xEEEE
   localparam logic [3:0] HDR_CHIP    = 4'd0;
   localparam logic [3:0] HDR_TIME_HI = 4'd1;
   localparam logic [3:0] HDR_TIME_LO = 4'd2;
   localparam logic [3:0] HDR_TIME_TL = 4'd3;
   localparam logic [3:0] HDR_EVENT   = 4'd4;
   localparam logic [3:0] HDR_NCHAN   = 4'd5;
   localparam logic [3:0] HDR_LAST    = 4'd8;

   localparam int RSP_DATA_WIDTH = 144;

   typedef struct packed {
      logic        [5:0]  board_num;
      logic        [1:0]  chip_id;
      logic        [7:0]  channel_num;
      logic        [15:0] event_word;
      logic        [47:0] extended_event;
      logic        [39:0] timestamp;
      logic        [9:0]  sample_index;
      logic signed [11:0] adc_sample;
      logic               last_of_channel;
      logic               last_of_block;
   } result_type;

endpackage

// ----- hdl/daq_block_deframer.sv -----
// Block deframer: takes one raw byte per transaction on req_, pairs bytes
// big-endian into 16-bit words, locks once on sync 0xCACA, then parses blocks
// (header 0xEEEE, nine header words, per channel one channel word plus
// samples_per_channel sample words, one padding byte) and sends one rsp_
// transaction per sample word. Throughput is one byte per clock while rsp_ is
// not stalled. Each accepted byte enters the byte register, which feeds the
// parser logic; its result enters the result register when the byte register
// drains. The parser state advances only when the byte register drains into a
// free result register, so a stalled rsp_ side holds one result and one
// pending byte before req_tready drops. The sample count register (csr_)
// should be written between blocks; no clearing pass is needed after reset.
module daq_block_deframer #(
   parameter int SAMPLE_COUNT_BITS = daqbd_pkg::SAMPLE_COUNT_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // raw byte stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [7:0] data_byte
   // sample results
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [5:0] board_num, [7:6] chip_id, [15:8] channel_num, [31:16] event_word,
   // [79:32] extended_event, [119:80] timestamp, [129:120] sample_index,
   // [141:130] adc_sample, [143:142] zero
   output logic [daqbd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                                 rsp_tuser,   // [0] last_of_channel
   output logic                                 rsp_tlast,   // last_of_block
   // samples_per_channel register
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [daqbd_pkg::SPC_WIDTH-1:0]      csr_data
);

   // sample count register, kept at the counter width
   logic [SAMPLE_COUNT_BITS-1:0] spc_ff, spc_in;

   // byte register in front of the parser
   logic                         in_valid_ff, in_valid_in;
   logic [7:0]                   in_byte_ff, in_byte_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   daqbd_pkg::result_type        rsp_ff, rsp_in;

   logic                         consume;
   logic                         parse_valid;
   daqbd_pkg::result_type        parse_res;

   // byte register drains when the result register is free or being emptied
   assign consume    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || consume;
   assign csr_ready  = 1'b1;

   always_comb begin
      spc_in = spc_ff;
      if (csr_valid) begin
         spc_in = SAMPLE_COUNT_BITS'(16'(csr_data));
      end

      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (consume) begin
         rsp_valid_in = parse_valid;
         if (parse_valid) begin
            rsp_in = parse_res;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spc_ff       <= SAMPLE_COUNT_BITS'(daqbd_pkg::SPC_RESET);
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         spc_ff       <= spc_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff <= in_byte_in;
      rsp_ff     <= rsp_in;
   end

   daqbd_parser #(
      .SAMPLE_COUNT_BITS(SAMPLE_COUNT_BITS)
   ) u_parser (
      .clock               (clock),
      .reset               (reset),
      .step                (consume),
      .data_byte           (in_byte_ff),
      .samples_per_channel (spc_ff),
      .res_valid           (parse_valid),
      .res                 (parse_res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00,
                        rsp_ff.adc_sample,
                        rsp_ff.sample_index,
                        rsp_ff.timestamp,
                        rsp_ff.extended_event,
                        rsp_ff.event_word,
                        rsp_ff.channel_num,
                        rsp_ff.chip_id,
                        rsp_ff.board_num};
   assign rsp_tuser  = rsp_ff.last_of_channel;
   assign rsp_tlast  = rsp_ff.last_of_block;

   // end of block is always also end of channel
   a_block_end_is_channel_end: assert property (
      @(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser
   ) else $error("last_of_block without last_of_channel");

   // extended event carries the raw event word in its low half
   a_ext_event_low: assert property (
      @(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:32] == rsp_tdata[31:16]
   ) else $error("extended_event low word differs from event_word");

   // a held byte is never overwritten while the result side stalls
   a_no_byte_overwrite: assert property (
      @(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready
   ) else $error("byte register accepted while full and stalled");

endmodule

// ----- hdl/daqbd_parser.sv -----
// Word pairing and block parser; one byte per step, result combinational.
module daqbd_parser #(
   parameter int SAMPLE_COUNT_BITS = daqbd_pkg::SAMPLE_COUNT_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [7:0]                   data_byte,
   input  logic [SAMPLE_COUNT_BITS-1:0] samples_per_channel,
   output logic                         res_valid,
   output daqbd_pkg::result_type        res
);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_SEEK,
      PH_HEADER,
      PH_CHANNEL,
      PH_SAMPLES,
      PH_PAD
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic                         pending_ff, pending_in;
   logic [7:0]                   held_ff, held_in;
   logic [3:0]                   hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]                   chip_ff, chip_in;
   logic [39:0]                  ts_ff, ts_in;
   logic [15:0]                  event_ff, event_in;
   logic                         seen_ff, seen_in;
   logic [15:0]                  prior_ff, prior_in;
   logic [31:0]                  epoch_ff, epoch_in;
   logic [15:0]                  chan_left_ff, chan_left_in;
   logic [SAMPLE_COUNT_BITS-1:0] done_ff, done_in;
   logic [7:0]                   cur_chan_ff, cur_chan_in;

   logic [15:0]                  word;
   logic [15:0]                  chan_left_dec;
   logic [SAMPLE_COUNT_BITS-1:0] done_inc;
   logic [15:0]                  done_wide;
   logic                         last_ch;
   logic                         is_sample;

   assign word          = {held_ff, data_byte};
   assign chan_left_dec = chan_left_ff - 16'd1;
   assign done_inc      = done_ff + SAMPLE_COUNT_BITS'(1);
   assign done_wide     = 16'(done_ff);
   assign last_ch       = (done_inc == samples_per_channel);
   assign is_sample     = step && (phase_ff == PH_SAMPLES) && pending_ff;

   always_comb begin
      phase_in     = phase_ff;
      pending_in   = pending_ff;
      held_in      = held_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      chip_in      = chip_ff;
      ts_in        = ts_ff;
      event_in     = event_ff;
      seen_in      = seen_ff;
      prior_in     = prior_ff;
      epoch_in     = epoch_ff;
      chan_left_in = chan_left_ff;
      done_in      = done_ff;
      cur_chan_in  = cur_chan_ff;

      if (step) begin
         if (phase_ff == PH_PAD) begin
            // padding byte after a block, pairing restarts on the next byte
            pending_in = 1'b0;
            phase_in   = PH_SEEK;
         end else if (!pending_ff) begin
            held_in    = data_byte;
            pending_in = 1'b1;
         end else begin
            pending_in = 1'b0;
            case (phase_ff)
               PH_HUNT: begin
                  if (word == daqbd_pkg::SYNC_WORD) begin
                     phase_in = PH_SEEK;
                  end
               end
               PH_SEEK: begin
                  if (word == daqbd_pkg::HEADER_WORD) begin
                     hdr_cnt_in = '0;
                     phase_in   = PH_HEADER;
                  end
               end
               PH_HEADER: begin
                  case (hdr_cnt_ff)
                     daqbd_pkg::HDR_CHIP:    chip_in = word[7:0];
                     daqbd_pkg::HDR_TIME_HI: ts_in = {word, 24'd0};
                     daqbd_pkg::HDR_TIME_LO: ts_in = ts_ff | {16'd0, word, 8'd0};
                     daqbd_pkg::HDR_TIME_TL: ts_in = ts_ff | {32'd0, word[15:8]};
                     daqbd_pkg::HDR_EVENT: begin
                        // epoch steps only on a real 16-bit wrap, saturating
                        if (seen_ff && prior_ff > daqbd_pkg::WRAP_HIGH &&
                            word < daqbd_pkg::WRAP_LOW && epoch_ff != '1) begin
                           epoch_in = epoch_ff + 32'd1;
                        end
                        event_in = word;
                        prior_in = word;
                        seen_in  = 1'b1;
                     end
                     daqbd_pkg::HDR_NCHAN:   chan_left_in = word;
                     default: ;
                  endcase
                  if (hdr_cnt_ff >= daqbd_pkg::HDR_LAST) begin
                     hdr_cnt_in = '0;
                     phase_in   = (chan_left_ff == 16'd0) ? PH_PAD : PH_CHANNEL;
                  end else begin
                     hdr_cnt_in = hdr_cnt_ff + 4'd1;
                  end
               end
               PH_CHANNEL: begin
                  cur_chan_in = word[7:0];
                  done_in     = '0;
                  if (samples_per_channel == '0) begin
                     chan_left_in = chan_left_dec;
                     if (chan_left_dec == 16'd0) begin
                        phase_in = PH_PAD;
                     end
                  end else begin
                     phase_in = PH_SAMPLES;
                  end
               end
               PH_SAMPLES: begin
                  done_in = done_inc;
                  if (last_ch) begin
                     chan_left_in = chan_left_dec;
                     phase_in     = (chan_left_dec == 16'd0) ? PH_PAD : PH_CHANNEL;
                  end
               end
               default: phase_in = PH_SEEK;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         pending_ff   <= 1'b0;
         held_ff      <= '0;
         hdr_cnt_ff   <= '0;
         chip_ff      <= '0;
         ts_ff        <= '0;
         event_ff     <= '0;
         seen_ff      <= 1'b0;
         prior_ff     <= '0;
         epoch_ff     <= '0;
         chan_left_ff <= '0;
         done_ff      <= '0;
         cur_chan_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         pending_ff   <= pending_in;
         held_ff      <= held_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         chip_ff      <= chip_in;
         ts_ff        <= ts_in;
         event_ff     <= event_in;
         seen_ff      <= seen_in;
         prior_ff     <= prior_in;
         epoch_ff     <= epoch_in;
         chan_left_ff <= chan_left_in;
         done_ff      <= done_in;
         cur_chan_ff  <= cur_chan_in;
      end
   end

   assign res_valid = is_sample;

   always_comb begin
      res.board_num       = chip_ff[7:2];
      res.chip_id         = chip_ff[1:0];
      res.channel_num     = cur_chan_ff;
      res.event_word      = event_ff;
      res.extended_event  = {epoch_ff, event_ff};
      res.timestamp       = ts_ff;
      res.sample_index    = done_wide[9:0];
      res.adc_sample      = word[11:0];
      res.last_of_channel = last_ch;
      res.last_of_block   = last_ch && (chan_left_ff == 16'd1);
   end

endmodule
